/* src/htfsc_pkg.sv */
package htfsc_pkg;

   localparam int BYTE_W  = 8;
   localparam int SUM_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEAD_VALUE      = 2'd0,
      CSR_TAIL_VALUE      = 2'd1,
      CSR_SUM_START_INDEX = 2'd2,
      CSR_SUM_SEED        = 2'd3
   } csr_idx_type;

   // Frame status codes, valid on the last byte of a frame
   typedef enum logic [1:0] {
      STATUS_GOOD     = 2'd0,
      STATUS_BAD_SUM  = 2'd1,
      STATUS_OVERLONG = 2'd2
   } status_type;

   localparam logic [BYTE_W-1:0] HEAD_RESET      = 8'h02;
   localparam logic [BYTE_W-1:0] TAIL_RESET      = 8'h03;
   localparam logic [BYTE_W-1:0] START_IDX_RESET = 8'h01;
   localparam logic [SUM_W-1:0]  SEED_RESET      = 16'h0000;

   localparam logic [SUM_W-1:0]  CHK_HI_MASK = 16'h0FC0;
   localparam logic [SUM_W-1:0]  CHK_LO_MASK = 16'h003F;
   localparam int                CHK_SHIFT   = 6;
   localparam logic [BYTE_W-1:0] CHK_OFFSET  = 8'h40;

   typedef struct packed {
      logic [BYTE_W-1:0] head_value;
      logic [BYTE_W-1:0] tail_value;
      logic [BYTE_W-1:0] sum_start_index;
      logic [SUM_W-1:0]  sum_seed;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic [BYTE_W-1:0] byte_index;
      logic              last_of_frame;
      status_type        frame_status;
   } rsp_type;

endpackage

/* src/htfsc_csr.sv */
module htfsc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [htfsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [htfsc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output htfsc_pkg::cfg_type                  cfg
);

   htfsc_pkg::cfg_type cfg_ff;
   htfsc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (htfsc_pkg::csr_idx_type'(csr_index))
            htfsc_pkg::CSR_HEAD_VALUE:      cfg_in.head_value      = csr_wdata[7:0];
            htfsc_pkg::CSR_TAIL_VALUE:      cfg_in.tail_value      = csr_wdata[7:0];
            htfsc_pkg::CSR_SUM_START_INDEX: cfg_in.sum_start_index = csr_wdata[7:0];
            htfsc_pkg::CSR_SUM_SEED:        cfg_in.sum_seed        = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head_value      <= htfsc_pkg::HEAD_RESET;
         cfg_ff.tail_value      <= htfsc_pkg::TAIL_RESET;
         cfg_ff.sum_start_index <= htfsc_pkg::START_IDX_RESET;
         cfg_ff.sum_seed        <= htfsc_pkg::SEED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* src/htfsc_engine.sv */
module htfsc_engine #(
   parameter int MAX_FRAME = 255
) (
   input  logic                            clock,
   input  logic                            reset,
   input  htfsc_pkg::cfg_type              cfg,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [htfsc_pkg::BYTE_W-1:0]    in_byte,
   output logic                            out_valid,
   input  logic                            out_ready,
   output htfsc_pkg::rsp_type              out_rsp
);

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_BODY = 2'd1,
      PH_CHK1 = 2'd2,
      PH_CHK2 = 2'd3
   } phase_type;

   localparam logic [htfsc_pkg::BYTE_W-1:0] LAST_BODY_IDX =
      htfsc_pkg::BYTE_W'(MAX_FRAME - 3);

   // Input stage
   logic                          stage_valid_ff, stage_valid_in;
   logic [htfsc_pkg::BYTE_W-1:0]  stage_byte_ff;

   // Frame state
   phase_type                     phase_ff, phase_in;
   logic [htfsc_pkg::BYTE_W-1:0]  position_ff, position_in;
   logic [htfsc_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic                          chk1_ok_ff, chk1_ok_in;

   // Result register
   logic                          out_valid_ff, out_valid_in;
   htfsc_pkg::rsp_type            rsp_ff, rsp_in;

   logic                          advance, step, has_rsp;
   logic [htfsc_pkg::SUM_W-1:0]   inv_sum;
   logic [htfsc_pkg::BYTE_W-1:0]  expect_hi, expect_lo, b;
   logic                          in_sum_range;

   assign advance  = !out_valid_ff || out_ready;
   assign step     = stage_valid_ff && advance;
   assign in_ready = !stage_valid_ff || advance;

   assign b         = stage_byte_ff;
   assign inv_sum   = ~sum_ff;
   assign expect_hi = htfsc_pkg::BYTE_W'((inv_sum & htfsc_pkg::CHK_HI_MASK)
                      >> htfsc_pkg::CHK_SHIFT) + htfsc_pkg::CHK_OFFSET;
   assign expect_lo = htfsc_pkg::BYTE_W'(inv_sum & htfsc_pkg::CHK_LO_MASK)
                      + htfsc_pkg::CHK_OFFSET;
   assign in_sum_range = (position_ff >= cfg.sum_start_index);

   always_comb begin
      phase_in    = phase_ff;
      position_in = position_ff;
      sum_in      = sum_ff;
      chk1_ok_in  = chk1_ok_ff;
      has_rsp     = 1'b0;
      rsp_in.frame_byte    = b;
      rsp_in.byte_index    = position_ff;
      rsp_in.last_of_frame = 1'b0;
      rsp_in.frame_status  = htfsc_pkg::STATUS_GOOD;
      case (phase_ff)
         PH_HUNT: begin
            if (b == cfg.head_value) begin
               has_rsp           = 1'b1;
               rsp_in.byte_index = '0;
               sum_in = (cfg.sum_start_index == '0)
                        ? cfg.sum_seed + htfsc_pkg::SUM_W'(b) : cfg.sum_seed;
               position_in = htfsc_pkg::BYTE_W'(1);
               phase_in    = (b == cfg.tail_value) ? PH_CHK1 : PH_BODY;
            end
         end
         PH_BODY: begin
            has_rsp = 1'b1;
            if (in_sum_range) begin
               sum_in = sum_ff + htfsc_pkg::SUM_W'(b);
            end
            if (b == cfg.tail_value) begin
               position_in = position_ff + 1'b1;
               phase_in    = PH_CHK1;
            end else if (position_ff >= LAST_BODY_IDX) begin
               // cut off: no room left for tail and check bytes
               rsp_in.last_of_frame = 1'b1;
               rsp_in.frame_status  = htfsc_pkg::STATUS_OVERLONG;
               position_in = '0;
               phase_in    = PH_HUNT;
            end else begin
               position_in = position_ff + 1'b1;
            end
         end
         PH_CHK1: begin
            has_rsp     = 1'b1;
            chk1_ok_in  = (b == expect_hi);
            position_in = position_ff + 1'b1;
            phase_in    = PH_CHK2;
         end
         PH_CHK2: begin
            has_rsp              = 1'b1;
            rsp_in.last_of_frame = 1'b1;
            rsp_in.frame_status  = (chk1_ok_ff && (b == expect_lo))
                                   ? htfsc_pkg::STATUS_GOOD : htfsc_pkg::STATUS_BAD_SUM;
            position_in = '0;
            chk1_ok_in  = 1'b0;
            phase_in    = PH_HUNT;
         end
         default: phase_in = PH_HUNT;
      endcase
   end

   assign stage_valid_in = (in_valid && in_ready) ? 1'b1 : (step ? 1'b0 : stage_valid_ff);
   assign out_valid_in   = (step && has_rsp) || (out_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         phase_ff       <= PH_HUNT;
         position_ff    <= '0;
         sum_ff         <= '0;
         chk1_ok_ff     <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
         if (step) begin
            phase_ff    <= phase_in;
            position_ff <= position_in;
            sum_ff      <= sum_in;
            chk1_ok_ff  <= chk1_ok_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         stage_byte_ff <= in_byte;
      end
      if (step && has_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

/* src/head_tail_frame_sum_checker_top.sv */
// Head/tail frame checker with a 6+6 bit complement-sum check. Received bytes
// enter one per transaction on the req_ channel. The block drops bytes until
// one equals head_value, then echoes every frame byte with its index on the
// rsp_ channel through the first tail_value byte and two check bytes; the
// last byte of a frame carries last_of_frame and the status (good, bad sum,
// overlong). After a failure hunting resumes at the next byte. Rate: one
// byte per cycle sustained while rsp_ready stays high; each byte passes
// through the input register and then the result register before its result
// appears on rsp_, where it is held until taken. The state update is one
// 16-bit add and a few compares. Write configuration only while no
// transaction is in flight.
module head_tail_frame_sum_checker_top #(
   parameter int MAX_FRAME = 255
) (
   input  logic         clock,
   input  logic         reset,
   // configuration
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata,
   // received bytes
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_rx_byte,
   // frame bytes
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [7:0]   rsp_frame_byte,
   output logic [7:0]   rsp_byte_index,
   output logic         rsp_last_of_frame,
   output logic [1:0]   rsp_frame_status
);

   htfsc_pkg::cfg_type cfg;
   htfsc_pkg::rsp_type rsp;

   // Hold the configuration registers
   htfsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Input register, frame state and result register
   htfsc_engine #(
      .MAX_FRAME (MAX_FRAME)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_byte   (req_rx_byte),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_rsp   (rsp)
   );

   // Unpack the result transaction onto its ports
   assign rsp_frame_byte    = rsp.frame_byte;
   assign rsp_byte_index    = rsp.byte_index;
   assign rsp_last_of_frame = rsp.last_of_frame;
   assign rsp_frame_status  = rsp.frame_status;

endmodule

/* src/htfsc_checker.sv */
module htfsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_byte_index,
   input logic        rsp_last_of_frame,
   input logic [1:0]  rsp_frame_status
);

   // status is only reported on the last byte of a frame
   a_status_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_frame) |-> (rsp_frame_status == htfsc_pkg::STATUS_GOOD))
      else $error("status set on a byte that is not last");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_status != 2'd3))
      else $error("undefined frame status");

   // a frame never reaches index 255
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_index != 8'hFF))
      else $error("frame index out of range");

   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result pending right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped before accepted");

endmodule

bind head_tail_frame_sum_checker_top htfsc_checker u_htfsc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_byte_index    (rsp_byte_index),
   .rsp_last_of_frame (rsp_last_of_frame),
   .rsp_frame_status  (rsp_frame_status)
);

/* tb/tb_head_tail_frame_sum_checker_top.sv */
`timescale 1ns / 1ps

module tb_head_tail_frame_sum_checker_top;

   localparam int MAX_FRAME    = 255;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1750;
   localparam int NUM_PHASES   = 12;
   // result register sits behind the input register; leave a wide margin
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_OFF_LEN = 300;
   localparam int NUM_DIR_ROWS = 23;

   // register field of byte rows, unused there
   localparam htfsc_pkg::csr_idx_type NO_CSR = htfsc_pkg::CSR_HEAD_VALUE;

   typedef enum logic [1:0] {FR_HUNT, FR_BODY, FR_CHECK_HI, FR_CHECK_LO} frame_phase_type;
   typedef enum bit {ROW_RX_BYTE, ROW_CSR_WRITE} dir_kind_type;

   // One row of the directed table: either a received byte or a register write.
   // Byte rows with typed set carry their expected result; the rest go through
   // the frame predictor.
   typedef struct {
      dir_kind_type           kind;
      htfsc_pkg::csr_idx_type csr;
      logic [15:0]            value;
      bit                     typed;
      bit                     has_rsp;
      htfsc_pkg::rsp_type     exp;
   } dir_row_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [1:0]  csr_index   = '0;
   logic [15:0] csr_wdata   = '0;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic [7:0]  rsp_frame_byte;
   logic [7:0]  rsp_byte_index;
   logic        rsp_last_of_frame;
   logic [1:0]  rsp_frame_status;

   // Predictor copy of the registers and the framing state
   htfsc_pkg::cfg_type frame_cfg;
   frame_phase_type    fr_phase;
   logic [7:0]         fr_pos;
   logic [15:0]        fr_sum;
   bit                 fr_hi_ok;

   // Frame bytes predicted but not yet seen on the rsp_ channel, oldest first
   htfsc_pkg::rsp_type frame_bytes_due [$];

   // Side info for the byte currently offered on req_
   bit                 cur_typed = 1'b0;
   bit                 cur_has   = 1'b0;
   htfsc_pkg::rsp_type cur_exp   = '0;

   int mismatch_count = 0;
   int cycle_count    = 0;
   int items_sent     = 0;
   int send_idle_pct  = 0;
   int stall_pct      = 0;
   bit hold_off_req   = 1'b0;
   int hold_off_left  = 0;

   dir_row_type dir_table [NUM_DIR_ROWS] = '{
      // hunting bytes that are not the head: dropped
      '{ROW_RX_BYTE, NO_CSR, 16'h0000, 1'b1, 1'b0, '0},
      '{ROW_RX_BYTE, NO_CSR, 16'h00FF, 1'b1, 1'b0, '0},
      // shortest good frame with reset registers: head, tail, checks
      '{ROW_RX_BYTE, NO_CSR, 16'h0002, 1'b1, 1'b1, '{8'h02, 8'd0, 1'b0, htfsc_pkg::STATUS_GOOD}},
      '{ROW_RX_BYTE, NO_CSR, 16'h0003, 1'b1, 1'b1, '{8'h03, 8'd1, 1'b0, htfsc_pkg::STATUS_GOOD}},
      '{ROW_RX_BYTE, NO_CSR, 16'h007F, 1'b1, 1'b1, '{8'h7F, 8'd2, 1'b0, htfsc_pkg::STATUS_GOOD}},
      '{ROW_RX_BYTE, NO_CSR, 16'h007C, 1'b1, 1'b1, '{8'h7C, 8'd3, 1'b1, htfsc_pkg::STATUS_GOOD}},
      // same frame, wrong second check byte
      '{ROW_RX_BYTE, NO_CSR, 16'h0002, 1'b1, 1'b1, '{8'h02, 8'd0, 1'b0, htfsc_pkg::STATUS_GOOD}},
      '{ROW_RX_BYTE, NO_CSR, 16'h0003, 1'b1, 1'b1, '{8'h03, 8'd1, 1'b0, htfsc_pkg::STATUS_GOOD}},
      '{ROW_RX_BYTE, NO_CSR, 16'h007F, 1'b1, 1'b1, '{8'h7F, 8'd2, 1'b0, htfsc_pkg::STATUS_GOOD}},
      '{ROW_RX_BYTE, NO_CSR, 16'h0000, 1'b1, 1'b1,
        '{8'h00, 8'd3, 1'b1, htfsc_pkg::STATUS_BAD_SUM}},
      // frame with a body, checked by the predictor
      '{ROW_RX_BYTE, NO_CSR, 16'h0002, 1'b1, 1'b1, '{8'h02, 8'd0, 1'b0, htfsc_pkg::STATUS_GOOD}},
      '{ROW_RX_BYTE, NO_CSR, 16'h00FF, 1'b0, 1'b0, '0},
      '{ROW_RX_BYTE, NO_CSR, 16'h0080, 1'b0, 1'b0, '0},
      '{ROW_RX_BYTE, NO_CSR, 16'h0003, 1'b0, 1'b0, '0},
      '{ROW_RX_BYTE, NO_CSR, 16'h0079, 1'b0, 1'b0, '0},
      '{ROW_RX_BYTE, NO_CSR, 16'h007D, 1'b0, 1'b0, '0},
      // head equal to tail, sum from index zero, seed at its top value
      '{ROW_CSR_WRITE, htfsc_pkg::CSR_HEAD_VALUE,      16'h0055, 1'b0, 1'b0, '0},
      '{ROW_CSR_WRITE, htfsc_pkg::CSR_TAIL_VALUE,      16'h0055, 1'b0, 1'b0, '0},
      '{ROW_CSR_WRITE, htfsc_pkg::CSR_SUM_START_INDEX, 16'h0000, 1'b0, 1'b0, '0},
      '{ROW_CSR_WRITE, htfsc_pkg::CSR_SUM_SEED,        16'hFFFF, 1'b0, 1'b0, '0},
      '{ROW_RX_BYTE, NO_CSR, 16'h0055, 1'b1, 1'b1, '{8'h55, 8'd0, 1'b0, htfsc_pkg::STATUS_GOOD}},
      '{ROW_RX_BYTE, NO_CSR, 16'h007E, 1'b1, 1'b1, '{8'h7E, 8'd1, 1'b0, htfsc_pkg::STATUS_GOOD}},
      '{ROW_RX_BYTE, NO_CSR, 16'h006B, 1'b1, 1'b1, '{8'h6B, 8'd2, 1'b1, htfsc_pkg::STATUS_GOOD}}
   };

   head_tail_frame_sum_checker_top #(
      .MAX_FRAME(MAX_FRAME)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_frame_status  (rsp_frame_status)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Expected check bytes: complement of the sum, split 6+6, offset into ASCII
   function automatic logic [7:0] check_hi(input logic [15:0] chk_sum);
      logic [15:0] field;
      field = (~chk_sum & htfsc_pkg::CHK_HI_MASK) >> htfsc_pkg::CHK_SHIFT;
      return field[7:0] + htfsc_pkg::CHK_OFFSET;
   endfunction

   function automatic logic [7:0] check_lo(input logic [15:0] chk_sum);
      logic [15:0] field;
      field = ~chk_sum & htfsc_pkg::CHK_LO_MASK;
      return field[7:0] + htfsc_pkg::CHK_OFFSET;
   endfunction

   // Advance the framing state by one received byte; return the echoed byte
   // with its index and status, if the byte belongs to a frame.
   function automatic void predict_frame_byte(input logic [7:0] b, output bit has_rsp,
                                              output htfsc_pkg::rsp_type r);
      has_rsp = 1'b1;
      r.frame_byte    = b;
      r.byte_index    = fr_pos;
      r.last_of_frame = 1'b0;
      r.frame_status  = htfsc_pkg::STATUS_GOOD;
      case (fr_phase)
         FR_HUNT: begin
            if (b != frame_cfg.head_value) begin
               has_rsp = 1'b0;
            end else begin
               fr_sum = frame_cfg.sum_seed;
               if (frame_cfg.sum_start_index == 8'd0) fr_sum = fr_sum + 16'(b);
               r.byte_index = 8'd0;
               fr_pos = 8'd1;
               // a head that is also the tail goes straight to the checks
               if (b == frame_cfg.tail_value) fr_phase = FR_CHECK_HI;
               else fr_phase = FR_BODY;
            end
         end
         FR_BODY: begin
            if (fr_pos >= frame_cfg.sum_start_index) fr_sum = fr_sum + 16'(b);
            if (b == frame_cfg.tail_value) begin
               fr_pos   = fr_pos + 8'd1;
               fr_phase = FR_CHECK_HI;
            end else if (int'(fr_pos) >= MAX_FRAME - 3) begin
               // no room left for tail and checks: cut the frame off
               r.last_of_frame = 1'b1;
               r.frame_status  = htfsc_pkg::STATUS_OVERLONG;
               fr_pos   = 8'd0;
               fr_phase = FR_HUNT;
            end else begin
               fr_pos = fr_pos + 8'd1;
            end
         end
         FR_CHECK_HI: begin
            fr_hi_ok = (b == check_hi(fr_sum));
            fr_pos   = fr_pos + 8'd1;
            fr_phase = FR_CHECK_LO;
         end
         default: begin
            r.last_of_frame = 1'b1;
            if (fr_hi_ok && b == check_lo(fr_sum)) r.frame_status = htfsc_pkg::STATUS_GOOD;
            else r.frame_status = htfsc_pkg::STATUS_BAD_SUM;
            fr_pos   = 8'd0;
            fr_hi_ok = 1'b0;
            fr_phase = FR_HUNT;
         end
      endcase
   endfunction

   // Scoreboard: sample both channels at the rising edge. Retire a result
   // before pushing the prediction of a byte accepted in the same cycle, so a
   // result can never match its own byte.
   always @(posedge clock) begin
      htfsc_pkg::rsp_type got;
      htfsc_pkg::rsp_type want;
      htfsc_pkg::rsp_type pred;
      bit                 has_rsp;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.frame_byte    = rsp_frame_byte;
            got.byte_index    = rsp_byte_index;
            got.last_of_frame = rsp_last_of_frame;
            got.frame_status  = htfsc_pkg::status_type'(rsp_frame_status);
            if (frame_bytes_due.size() == 0) begin
               $display("%0t: unexpected frame byte %02h at index %0d", $time,
                        got.frame_byte, got.byte_index);
               mismatch_count++;
            end else begin
               want = frame_bytes_due.pop_front();
               if (got.frame_byte !== want.frame_byte) begin
                  $display("%0t: frame_byte expected %02h actual %02h", $time,
                           want.frame_byte, got.frame_byte);
                  mismatch_count++;
               end
               if (got.byte_index !== want.byte_index) begin
                  $display("%0t: byte_index expected %0d actual %0d", $time,
                           want.byte_index, got.byte_index);
                  mismatch_count++;
               end
               if (got.last_of_frame !== want.last_of_frame) begin
                  $display("%0t: last_of_frame expected %0d actual %0d", $time,
                           want.last_of_frame, got.last_of_frame);
                  mismatch_count++;
               end
               if (got.frame_status !== want.frame_status) begin
                  $display("%0t: frame_status expected %0d actual %0d", $time,
                           want.frame_status, got.frame_status);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_frame_byte(req_rx_byte, has_rsp, pred);
            // typed rows override the predictor, which still advances
            if (cur_typed) begin
               has_rsp = cur_has;
               pred    = cur_exp;
            end
            if (has_rsp) frame_bytes_due.push_back(pred);
         end
      end
   end

   // Receiver: stall at random, or hold off for a long stretch on request so
   // the block backs up and drops req_ready.
   always @(negedge clock) begin
      if (hold_off_req) begin
         hold_off_req  = 1'b0;
         hold_off_left = HOLD_OFF_LEN;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached", $time);
         $display("** head_tail_frame_sum_checker_top: FAILED **");
         $finish;
      end
   end

   // Offer one byte on req_ and hold it until accepted. Entered and left at a
   // falling edge; valid stays high on exit so back-to-back bytes stream.
   task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                            input bit has_rsp = 1'b0,
                            input htfsc_pkg::rsp_type exp = '0);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_rx_byte = b;
      cur_typed   = typed;
      cur_has     = has_rsp;
      cur_exp     = exp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Write one register once the block has drained.
   task automatic csr_write(input htfsc_pkg::csr_idx_type idx, input logic [15:0] data);
      req_valid = 1'b0;
      while (frame_bytes_due.size() != 0) @(negedge clock);
      // let dropped hunting bytes clear the pipeline too
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      case (idx)
         htfsc_pkg::CSR_HEAD_VALUE:      frame_cfg.head_value      = data[7:0];
         htfsc_pkg::CSR_TAIL_VALUE:      frame_cfg.tail_value      = data[7:0];
         htfsc_pkg::CSR_SUM_START_INDEX: frame_cfg.sum_start_index = data[7:0];
         default:                        frame_cfg.sum_seed        = data;
      endcase
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Send a frame: head, body bytes free of the tail value, then tail and the
   // two check bytes. Overlong frames run on until the block cuts them off;
   // truncated frames stop before the tail. Optionally spoil one check byte.
   task automatic send_frame(input int body_len, input bit overlong, input bit no_tail,
                             input bit corrupt);
      logic [15:0] chk_sum;
      logic [7:0]  b;
      logic [7:0]  hi;
      logic [7:0]  lo;
      int          last_idx;
      if (frame_cfg.head_value == frame_cfg.tail_value) begin
         body_len = 0;
         overlong = 1'b0;
         no_tail  = 1'b0;
      end
      if (overlong) last_idx = MAX_FRAME - 3;
      else if (no_tail) last_idx = body_len;
      else last_idx = body_len + 1;
      chk_sum = frame_cfg.sum_seed;
      for (int idx = 0; idx <= last_idx; idx++) begin
         if (idx == 0) begin
            b = frame_cfg.head_value;
         end else if (idx == last_idx && !overlong && !no_tail) begin
            b = frame_cfg.tail_value;
         end else begin
            b = 8'($urandom_range(255));
            if (b == frame_cfg.tail_value) b = b ^ 8'h01;
         end
         if (idx >= int'(frame_cfg.sum_start_index)) chk_sum = chk_sum + 16'(b);
         send_byte(b);
         items_sent++;
      end
      if (!overlong && !no_tail) begin
         hi = check_hi(chk_sum);
         lo = check_lo(chk_sum);
         if (corrupt) begin
            if ($urandom_range(1) == 0) hi = hi ^ 8'($urandom_range(1, 255));
            else lo = lo ^ 8'($urandom_range(1, 255));
         end
         send_byte(hi);
         send_byte(lo);
         items_sent += 2;
      end
   endtask

   initial begin
      int          phase_target;
      int          pick;
      logic [7:0]  new_head;
      logic [7:0]  new_tail;
      logic [7:0]  new_start;
      logic [15:0] new_seed;

      // predictor starts from the reset state
      frame_cfg.head_value      = htfsc_pkg::HEAD_RESET;
      frame_cfg.tail_value      = htfsc_pkg::TAIL_RESET;
      frame_cfg.sum_start_index = htfsc_pkg::START_IDX_RESET;
      frame_cfg.sum_seed        = htfsc_pkg::SEED_RESET;
      fr_phase = FR_HUNT;
      fr_pos   = 8'd0;
      fr_sum   = 16'd0;
      fr_hi_ok = 1'b0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table, no idling on either side
      foreach (dir_table[i]) begin
         if (dir_table[i].kind == ROW_CSR_WRITE)
            csr_write(dir_table[i].csr, dir_table[i].value);
         else
            send_byte(dir_table[i].value[7:0], dir_table[i].typed, dir_table[i].has_rsp,
                      dir_table[i].exp);
      end

      // Random phases: new register setting and idling pattern each phase
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin
               new_head = 8'h00; new_tail = 8'hFF; new_start = 8'h00; new_seed = 16'h0000;
            end
            1: begin
               new_head = 8'hFF; new_tail = 8'h00; new_start = 8'hFF; new_seed = 16'hFFFF;
            end
            2: begin
               // head doubles as tail
               new_head  = 8'($urandom_range(255));
               new_tail  = new_head;
               new_start = 8'($urandom_range(3));
               new_seed  = 16'($urandom_range(65535));
            end
            3: begin
               // start index beyond any tail: checks come from the seed alone
               new_head = htfsc_pkg::HEAD_RESET; new_tail = htfsc_pkg::TAIL_RESET;
               new_start = 8'hFF;
               new_seed = 16'($urandom_range(65535));
            end
            default: begin
               new_head = 8'($urandom_range(255));
               new_tail = 8'($urandom_range(255));
               if ($urandom_range(3) == 0) new_start = 8'($urandom_range(255));
               else new_start = 8'($urandom_range(12));
               new_seed = 16'($urandom_range(65535));
            end
         endcase
         csr_write(htfsc_pkg::CSR_HEAD_VALUE, {8'h00, new_head});
         csr_write(htfsc_pkg::CSR_TAIL_VALUE, {8'h00, new_tail});
         csr_write(htfsc_pkg::CSR_SUM_START_INDEX, {8'h00, new_start});
         csr_write(htfsc_pkg::CSR_SUM_SEED, new_seed);

         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 58; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 58; end
            default: begin send_idle_pct = 12; stall_pct = 12; end
         endcase
         // back-pressure: receiver holds off while the sender keeps streaming
         if (p == 4) hold_off_req = 1'b1;

         // the two full-length frames of the first phases come out of the budget
         phase_target = items_sent + (RANDOM_ITEMS - 2 * MAX_FRAME) / NUM_PHASES;
         if (p == 0) send_frame(0, 1'b1, 1'b0, 1'b0);
         if (p == 1) send_frame(MAX_FRAME - 4, 1'b0, 1'b0, 1'b0);
         while (items_sent < phase_target) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
               // line noise, now and then a stray head
               repeat ($urandom_range(1, 4)) begin
                  if ($urandom_range(3) == 0) send_byte(frame_cfg.head_value);
                  else send_byte(8'($urandom_range(255)));
                  items_sent++;
               end
            end else if (pick < 14) begin
               send_frame($urandom_range(1, 3), 1'b0, 1'b1, 1'b0);
            end else if (pick < 15) begin
               if ($urandom_range(1) == 0) send_frame(0, 1'b1, 1'b0, 1'b0);
               else send_frame(MAX_FRAME - 4, 1'b0, 1'b0, 1'b0);
            end else begin
               send_frame($urandom_range(12), 1'b0, 1'b0, $urandom_range(99) < 20);
            end
         end
      end

      // Drain: wait for every expected frame byte, then idle for DRAIN_CYCLES
      req_valid = 1'b0;
      while (frame_bytes_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("** head_tail_frame_sum_checker_top: PASSED **");
      end else begin
         $display("** head_tail_frame_sum_checker_top: FAILED **");
      end
      $finish;
   end

endmodule

/* sim.f */
src/htfsc_pkg.sv
src/htfsc_csr.sv
src/htfsc_engine.sv
src/head_tail_frame_sum_checker_top.sv
src/htfsc_checker.sv
tb/tb_head_tail_frame_sum_checker_top.sv
